### design/pea_pkg.sv
// Shared types and constants for the page extent allocator.
// No dependencies; every other design file imports this package.
package pea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int PAGE_W      = 36;
  localparam int COUNT_W     = 31;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int SUM_W       = PAGE_W + IDX_W;
  localparam int ALU_W       = SUM_W + 2;
  localparam int MRG_W       = PAGE_W + 2;

  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_NOFIT  = 3'd1,
    STS_DOUBLE = 3'd2,
    STS_ZERO   = 3'd3,
    STS_FULL   = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] len;
  } entry_t;

endpackage

### design/pea_table.sv
// Free extent table: one write port and one read port with registered data.
// Depends on pea_pkg for the entry type and the table depth.
module pea_table (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pea_pkg::IDX_W-1:0]  waddr_i,
  input  pea_pkg::entry_t            wdata_i,
  input  logic [pea_pkg::IDX_W-1:0]  raddr_i,
  output pea_pkg::entry_t            rdata_o
);
  import pea_pkg::*;

  entry_t mem_q [MAX_EXTENTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/pea_alu.sv
// Shared adder/subtractor used by the allocator sequencer steps that add or subtract.
// Depends on pea_pkg for the request type and datapath width.
module pea_alu (
  input  pea_pkg::alu_req_t          req_i,
  output logic [pea_pkg::ALU_W-1:0]  y_o,
  output logic                       borrow_o
);
  import pea_pkg::*;

  logic [ALU_W:0] res;

  always_comb begin
    case (req_i.op)
      ALU_ADD: res = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: res = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: res = '0;
    endcase
  end

  assign y_o      = res[ALU_W-1:0];
  assign borrow_o = res[ALU_W];

endmodule

### design/page_extent_allocator_core.sv
// First-fit page extent allocator with coalescing on free. The walk reads one
// extent per cycle through the single table read port. Removing or inserting
// an extent then moves the entries above its slot one per cycle, so the
// entries walked and moved together never exceed the extents in the table.
// A request may also wait for the output register; the input stalls while a
// request is at work.
// The result waits in an output register, and the next request is accepted
// while it does. Writing a nonzero pool_pages resets the table to one extent.
module page_extent_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [pea_pkg::PAGE_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [pea_pkg::PAGE_W-1:0]   page_number_i,
  input  logic [pea_pkg::COUNT_W-1:0]  page_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pea_pkg::status_e             status_o,
  output logic [pea_pkg::PAGE_W-1:0]   base_page_o,
  output logic [pea_pkg::PAGE_W-1:0]   free_pages_o,
  output logic [pea_pkg::PAGE_W-1:0]   used_pages_o
);
  import pea_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AWALK, S_ABASE, S_FWALK, S_FJN, S_FM1, S_FM2,
    S_SHL, S_SHR, S_INS, S_SUM1, S_SUM2, S_SUM3, S_USED
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d, count_q, count_d, pos_q, pos_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PAGE_W-1:0]  pbase_q, pbase_d, pages_q, pages_d;
  logic               cmd_q, cmd_d;
  logic [PAGE_W-1:0]  addr_q, addr_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  status_e            sts_q, sts_d;
  logic [PAGE_W-1:0]  base_q, base_d, ent_start_q, ent_start_d, rest_q, rest_d;
  logic [PAGE_W-1:0]  prev_start_q, prev_start_d, prev_len_q, prev_len_d;
  logic [PAGE_W:0]    prev_end_q, prev_end_d;
  logic [PAGE_W-1:0]  nxt_start_q, nxt_start_d, nxt_len_q, nxt_len_d;
  logic               have_prev_q, have_prev_d, has_next_q, has_next_d;
  logic               jp_q, jp_d, jn_q, jn_d;
  logic [MRG_W-1:0]   tmp_q, tmp_d;
  logic [PAGE_W-1:0]  rem_a_q, rem_a_d, rem_b_q, rem_b_d, add_q, add_d;
  logic               out_vld_q, out_vld_d;
  status_e            o_sts_q, o_sts_d;
  logic [PAGE_W-1:0]  o_base_q, o_base_d, o_free_q, o_free_d, o_used_q, o_used_d;

  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr, tbl_raddr;
  entry_t             tbl_wdata, rdata;
  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_y;
  logic               alu_borrow;

  logic [CNT_W-1:0]   idx_p1, idx_m1, pos_p1, pos_m1, cnt_m1;
  logic [PAGE_W-1:0]  free36, new_len;

  assign idx_p1 = idx_q + CNT_W'(1);
  assign idx_m1 = idx_q - CNT_W'(1);
  assign pos_p1 = pos_q + CNT_W'(1);
  assign pos_m1 = pos_q - CNT_W'(1);
  assign cnt_m1 = count_q - CNT_W'(1);
  assign free36 = (sum_q > SUM_W'(PAGE_MAX)) ? PAGE_MAX : sum_q[PAGE_W-1:0];
  assign new_len = (alu_y > ALU_W'(PAGE_MAX)) ? PAGE_MAX : alu_y[PAGE_W-1:0];

  pea_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (rdata)
  );

  pea_alu u_alu (
    .req_i    (alu_req),
    .y_o      (alu_y),
    .borrow_o (alu_borrow)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    case (state_q)
      S_AWALK: alu_req = '{op: ALU_SUB, a: ALU_W'(rdata.len), b: ALU_W'(cnt_q)};
      S_ABASE: alu_req = '{op: ALU_ADD, a: ALU_W'(ent_start_q), b: ALU_W'(rest_q)};
      S_FWALK: alu_req = '{op: ALU_ADD, a: ALU_W'(rdata.start), b: ALU_W'(rdata.len)};
      S_FJN:   alu_req = '{op: ALU_ADD, a: ALU_W'(addr_q), b: ALU_W'(cnt_q)};
      S_FM1:   alu_req = '{op: ALU_ADD, a: ALU_W'(cnt_q),
                           b: jp_q ? ALU_W'(prev_len_q) : '0};
      S_FM2:   alu_req = '{op: ALU_ADD, a: ALU_W'(tmp_q),
                           b: jn_q ? ALU_W'(nxt_len_q) : '0};
      S_SUM1:  alu_req = '{op: ALU_SUB, a: ALU_W'(sum_q), b: ALU_W'(rem_a_q)};
      S_SUM2:  alu_req = '{op: ALU_SUB, a: ALU_W'(sum_q), b: ALU_W'(rem_b_q)};
      S_SUM3:  alu_req = '{op: ALU_ADD, a: ALU_W'(sum_q), b: ALU_W'(add_q)};
      S_USED:  alu_req = '{op: ALU_SUB, a: ALU_W'(pages_q), b: ALU_W'(free36)};
      default: alu_req = '{op: ALU_ADD, a: '0, b: '0};
    endcase
  end

  always_comb begin
    state_d = state_q;       idx_d = idx_q;           count_d = count_q;
    pos_d = pos_q;           sum_d = sum_q;           pbase_d = pbase_q;
    pages_d = pages_q;       cmd_d = cmd_q;           addr_d = addr_q;
    cnt_d = cnt_q;           sts_d = sts_q;           base_d = base_q;
    ent_start_d = ent_start_q; rest_d = rest_q;
    prev_start_d = prev_start_q; prev_len_d = prev_len_q; prev_end_d = prev_end_q;
    nxt_start_d = nxt_start_q;   nxt_len_d = nxt_len_q;
    have_prev_d = have_prev_q;   has_next_d = has_next_q;
    jp_d = jp_q;             jn_d = jn_q;             tmp_d = tmp_q;
    rem_a_d = rem_a_q;       rem_b_d = rem_b_q;       add_d = add_q;
    out_vld_d = out_vld_q & out_stall_i;
    o_sts_d = o_sts_q;       o_base_d = o_base_q;
    o_free_d = o_free_q;     o_used_d = o_used_q;
    tbl_we = 1'b0;
    tbl_waddr = idx_q[IDX_W-1:0];
    tbl_wdata = rdata;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i;
          addr_d = page_number_i;
          cnt_d = page_count_i;
          base_d = '0;
          have_prev_d = 1'b0;
          has_next_d = 1'b0;
          rem_a_d = '0;
          rem_b_d = '0;
          add_d = '0;
          idx_d = '0;
          sts_d = STS_OK;
          if (page_count_i == '0) begin
            sts_d = STS_ZERO;
            state_d = S_USED;
          end else if (command_i) begin
            state_d = S_FWALK;
          end else begin
            state_d = S_AWALK;
          end
        end
      end
      S_AWALK: begin
        if (idx_q == count_q) begin
          sts_d = STS_NOFIT;
          state_d = S_USED;
        end else if (!alu_borrow) begin
          rem_a_d = rdata.len;
          pos_d = idx_q;
          if (alu_y[PAGE_W-1:0] == '0) begin
            // The extent empties: hand back its start and close the gap.
            base_d = rdata.start;
            idx_d = idx_p1;
            state_d = S_SHL;
          end else begin
            tbl_we = 1'b1;
            tbl_wdata = '{start: rdata.start, len: alu_y[PAGE_W-1:0]};
            ent_start_d = rdata.start;
            rest_d = alu_y[PAGE_W-1:0];
            add_d = alu_y[PAGE_W-1:0];
            state_d = S_ABASE;
          end
        end else begin
          idx_d = idx_p1;
        end
      end
      S_ABASE: begin
        base_d = alu_y[PAGE_W-1:0];
        state_d = S_SUM1;
      end
      S_FWALK: begin
        pos_d = idx_q;
        if (idx_q == count_q) begin
          has_next_d = 1'b0;
          state_d = S_FJN;
        end else if (rdata.start < addr_q) begin
          if ({1'b0, addr_q} < alu_y[PAGE_W:0]) begin
            sts_d = STS_DOUBLE;
            state_d = S_USED;
          end else begin
            prev_start_d = rdata.start;
            prev_len_d = rdata.len;
            prev_end_d = alu_y[PAGE_W:0];
            have_prev_d = 1'b1;
            idx_d = idx_p1;
          end
        end else if (rdata.start == addr_q) begin
          sts_d = STS_DOUBLE;
          state_d = S_USED;
        end else begin
          has_next_d = 1'b1;
          nxt_start_d = rdata.start;
          nxt_len_d = rdata.len;
          state_d = S_FJN;
        end
      end
      S_FJN: begin
        jp_d = have_prev_q && (prev_end_q == {1'b0, addr_q});
        jn_d = has_next_q && (alu_y == ALU_W'(nxt_start_q));
        state_d = S_FM1;
      end
      S_FM1: begin
        tmp_d = alu_y[MRG_W-1:0];
        state_d = S_FM2;
      end
      S_FM2: begin
        add_d = new_len;
        if (jp_q) begin
          tbl_we = 1'b1;
          tbl_waddr = pos_m1[IDX_W-1:0];
          tbl_wdata = '{start: prev_start_q, len: new_len};
          rem_a_d = prev_len_q;
          if (jn_q) begin
            // Both neighbors merge: the next extent is absorbed and removed.
            rem_b_d = nxt_len_q;
            idx_d = pos_p1;
            state_d = S_SHL;
          end else begin
            state_d = S_SUM1;
          end
        end else if (jn_q) begin
          tbl_we = 1'b1;
          tbl_waddr = pos_q[IDX_W-1:0];
          tbl_wdata = '{start: addr_q, len: new_len};
          rem_a_d = nxt_len_q;
          state_d = S_SUM1;
        end else if (count_q == CNT_W'(MAX_EXTENTS)) begin
          sts_d = STS_FULL;
          state_d = S_USED;
        end else if (count_q == pos_q) begin
          state_d = S_INS;
        end else begin
          idx_d = cnt_m1;
          state_d = S_SHR;
        end
      end
      S_SHL: begin
        if (idx_q == count_q) begin
          count_d = cnt_m1;
          state_d = S_SUM1;
        end else begin
          tbl_we = 1'b1;
          tbl_waddr = idx_m1[IDX_W-1:0];
          tbl_wdata = rdata;
          idx_d = idx_p1;
        end
      end
      S_SHR: begin
        tbl_we = 1'b1;
        tbl_waddr = idx_p1[IDX_W-1:0];
        tbl_wdata = rdata;
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          idx_d = idx_m1;
        end
      end
      S_INS: begin
        tbl_we = 1'b1;
        tbl_waddr = pos_q[IDX_W-1:0];
        tbl_wdata = '{start: addr_q, len: PAGE_W'(cnt_q)};
        count_d = count_q + CNT_W'(1);
        state_d = S_SUM1;
      end
      S_SUM1: begin
        sum_d = alu_y[SUM_W-1:0];
        state_d = S_SUM2;
      end
      S_SUM2: begin
        sum_d = alu_y[SUM_W-1:0];
        state_d = S_SUM3;
      end
      S_SUM3: begin
        sum_d = alu_y[SUM_W-1:0];
        state_d = S_USED;
      end
      S_USED: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          o_sts_d = sts_q;
          o_base_d = (!cmd_q && sts_q == STS_OK) ? base_q : '0;
          o_free_d = free36;
          o_used_d = alu_borrow ? '0 : alu_y[PAGE_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_POOL_BASE) begin
        pbase_d = cfg_wdata_i;
      end else begin
        pages_d = cfg_wdata_i;
        count_d = (cfg_wdata_i != '0) ? CNT_W'(1) : '0;
        sum_d = SUM_W'(cfg_wdata_i);
        tbl_we = 1'b1;
        tbl_waddr = '0;
        tbl_wdata = '{start: pbase_q, len: cfg_wdata_i};
      end
    end
  end

  assign tbl_raddr = idx_d[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      count_q <= '0;
      sum_q <= '0;
      pbase_q <= '0;
      pages_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      count_q <= count_d;
      sum_q <= sum_d;
      pbase_q <= pbase_d;
      pages_q <= pages_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;           cmd_q <= cmd_d;           addr_q <= addr_d;
    cnt_q <= cnt_d;           sts_q <= sts_d;           base_q <= base_d;
    ent_start_q <= ent_start_d; rest_q <= rest_d;
    prev_start_q <= prev_start_d; prev_len_q <= prev_len_d; prev_end_q <= prev_end_d;
    nxt_start_q <= nxt_start_d;   nxt_len_q <= nxt_len_d;
    have_prev_q <= have_prev_d;   has_next_q <= has_next_d;
    jp_q <= jp_d;             jn_q <= jn_d;             tmp_q <= tmp_d;
    rem_a_q <= rem_a_d;       rem_b_q <= rem_b_d;       add_q <= add_d;
    o_sts_q <= o_sts_d;       o_base_q <= o_base_d;
    o_free_q <= o_free_d;     o_used_q <= o_used_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_vld_q;
  assign status_o     = o_sts_q;
  assign base_page_o  = o_base_q;
  assign free_pages_o = o_free_q;
  assign used_pages_o = o_used_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_EXTENTS))
    else $error("extent count exceeds table depth");

  a_result_from_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_USED))
    else $error("result loaded outside the result step");

  a_idle_write_is_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we && state_q == S_IDLE) |-> cfg_we_i)
    else $error("table written while idle without a configuration write");

  a_base_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STS_OK) |-> base_page_o == '0)
    else $error("base page reported on a failed request");

endmodule

### tb/page_extent_allocator_core_tb.sv
// Self-checking testbench for page_extent_allocator_core: a queue-fed driver,
// a monitor that checks each result against a first-fit free table predictor.
// Depends on pea_pkg and the page_extent_allocator_core RTL.
`timescale 1ns / 100ps

module page_extent_allocator_core_tb;
  import pea_pkg::*;

  localparam longint unsigned MASK36 = 64'hF_FFFF_FFFF;

  typedef struct {
    bit                cmd;
    bit [PAGE_W-1:0]   page;
    bit [COUNT_W-1:0]  count;
  } request_t;

  typedef struct {
    status_e           status;
    bit [PAGE_W-1:0]   base;
    bit [PAGE_W-1:0]   free_pages;
    bit [PAGE_W-1:0]   used_pages;
  } outcome_t;

  typedef struct {
    longint unsigned base;
    longint unsigned count;
  } range_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = CFG_POOL_BASE;
  logic [PAGE_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = 1'b0;
  logic [PAGE_W-1:0]   page_number_i = '0;
  logic [COUNT_W-1:0]  page_count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  status_e             status_o;
  logic [PAGE_W-1:0]   base_page_o;
  logic [PAGE_W-1:0]   free_pages_o;
  logic [PAGE_W-1:0]   used_pages_o;

  page_extent_allocator_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: free extents sorted by start page.
  longint unsigned pool_base_q, pool_pages_q, free_sum;
  longint unsigned ext_start [MAX_EXTENTS];
  longint unsigned ext_len   [MAX_EXTENTS];
  int              ext_num;

  request_t  pending_q[$];
  outcome_t  expected_q[$];
  range_t    granted_q[$];
  bit        idle_on = 1'b1;
  int        errors = 0;
  int        results_seen = 0;

  function automatic longint unsigned sat36(longint unsigned v);
    return (v > MASK36) ? MASK36 : v;
  endfunction

  function automatic void reload_table();
    ext_num = 0;
    if (pool_pages_q != 0) begin
      ext_start[0] = pool_base_q;
      ext_len[0]   = pool_pages_q;
      ext_num      = 1;
    end
    granted_q.delete();
  endfunction

  function automatic void drop_extent(int i);
    for (int k = i; k + 1 < ext_num; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k]   = ext_len[k+1];
    end
    ext_num--;
  endfunction

  function automatic status_e carve_pages(longint unsigned cnt, output longint unsigned base);
    longint unsigned rest;
    base = 0;
    for (int i = 0; i < ext_num; i++) begin
      if (ext_len[i] >= cnt) begin
        rest = ext_len[i] - cnt;
        if (rest == 0) begin
          base = ext_start[i];
          drop_extent(i);
        end else begin
          ext_len[i] = rest;
          base = (ext_start[i] + rest) & MASK36;
        end
        return STS_OK;
      end
    end
    return STS_NOFIT;
  endfunction

  function automatic status_e return_pages(longint unsigned addr, longint unsigned cnt);
    int i;
    bit has_next, join_prev, join_next;
    i = 0;
    while (i < ext_num && ext_start[i] < addr) begin
      if (addr < ext_start[i] + ext_len[i]) return STS_DOUBLE;
      i++;
    end
    has_next = i < ext_num;
    if (has_next && ext_start[i] == addr) return STS_DOUBLE;
    join_prev = i > 0 && ext_start[i-1] + ext_len[i-1] == addr;
    join_next = has_next && addr + cnt == ext_start[i];
    if (join_prev && join_next) begin
      ext_len[i-1] = sat36(ext_len[i-1] + cnt + ext_len[i]);
      drop_extent(i);
    end else if (join_prev) begin
      ext_len[i-1] = sat36(ext_len[i-1] + cnt);
    end else if (join_next) begin
      ext_start[i] = addr;
      ext_len[i]   = sat36(cnt + ext_len[i]);
    end else begin
      if (ext_num >= MAX_EXTENTS) return STS_FULL;
      for (int k = ext_num; k > i; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_len[k]   = ext_len[k-1];
      end
      ext_start[i] = addr;
      ext_len[i]   = cnt;
      ext_num++;
    end
    return STS_OK;
  endfunction

  function automatic outcome_t predict_outcome(request_t rq);
    outcome_t        o;
    longint unsigned base;
    range_t          g;
    base = 0;
    if (rq.count == 0) o.status = STS_ZERO;
    else if (rq.cmd == 1'b0) o.status = carve_pages(rq.count, base);
    else o.status = return_pages(rq.page, rq.count);
    free_sum = 0;
    for (int k = 0; k < ext_num; k++) free_sum = sat36(free_sum + ext_len[k]);
    o.base = (rq.cmd == 1'b0 && o.status == STS_OK) ? base[PAGE_W-1:0] : '0;
    o.free_pages = free_sum[PAGE_W-1:0];
    o.used_pages = (pool_pages_q > free_sum) ? PAGE_W'(pool_pages_q - free_sum) : '0;
    if (rq.cmd == 1'b0 && o.status == STS_OK) begin
      g.base = base;
      g.count = rq.count;
      granted_q.push_back(g);
    end
    return o;
  endfunction

  // Driver: one request per handshake, with a random gap drawn per request while idle_on is set.
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic     busy;
    request_t rq;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        rq.cmd = command_i;
        rq.page = page_number_i;
        rq.count = page_count_i;
        expected_q.push_back(predict_outcome(rq));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          rq = pending_q.pop_front();
          command_i     <= rq.cmd;
          page_number_i <= rq.page;
          page_count_i  <= rq.count;
          busy = 1'b1;
          gap_left <= idle_on ? $urandom_range(0, 3) : 0;
        end
      end
      in_valid_i <= busy;
    end
  end

  // Monitor: checks each accepted result and draws its own stall pattern.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    int       nxt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      nxt = stall_left;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d base %0h", $time, status_o,
                   base_page_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
            errors++;
          end
          if (base_page_o !== e.base) begin
            $display("%0t: base_page expected %0h actual %0h", $time, e.base, base_page_o);
            errors++;
          end
          if (free_pages_o !== e.free_pages) begin
            $display("%0t: free_pages expected %0h actual %0h", $time, e.free_pages,
                     free_pages_o);
            errors++;
          end
          if (used_pages_o !== e.used_pages) begin
            $display("%0t: used_pages expected %0h actual %0h", $time, e.used_pages,
                     used_pages_o);
            errors++;
          end
        end
        // A long hold-off once, so the block backs up and stalls its input.
        if (results_seen == 300) nxt = 600;
        else nxt = idle_on ? $urandom_range(0, 3) : 0;
      end else if (nxt > 0) begin
        nxt--;
      end
      stall_left  <= nxt;
      out_stall_i <= (nxt > 0);
    end
  end

  task automatic send(bit cmd, longint unsigned page, longint unsigned cnt);
    request_t rq;
    rq.cmd = cmd;
    rq.page = page[PAGE_W-1:0];
    rq.count = cnt[COUNT_W-1:0];
    pending_q.push_back(rq);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, longint unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[PAGE_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POOL_BASE) begin
      pool_base_q = value & MASK36;
    end else begin
      pool_pages_q = value & MASK36;
      reload_table();
    end
  endtask

  task automatic set_pool(longint unsigned base, longint unsigned pages);
    drain();
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_PAGES, pages);
  endtask

  // Mostly well-formed traffic: allocations and frees of granted ranges,
  // with some stray frees, zero counts and raw random fields mixed in.
  task automatic random_traffic(int n, int max_cnt);
    int      r, k;
    range_t  g;
    for (int j = 0; j < n; j++) begin
      while (pending_q.size() >= 3) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send(1'b0, {$urandom, $urandom}, $urandom_range(1, max_cnt));
      end else if (r < 75 && granted_q.size() > 0) begin
        k = $urandom_range(0, granted_q.size() - 1);
        g = granted_q[k];
        granted_q.delete(k);
        send(1'b1, g.base, g.count);
      end else if (r < 80) begin
        send(1'b1, pool_base_q + $urandom_range(0, 400), $urandom_range(1, 4));
      end else if (r < 85) begin
        send($urandom_range(0, 1), {$urandom, $urandom}, 0);
      end else if (r < 95) begin
        send($urandom_range(0, 1), {$urandom, $urandom}, $urandom);
      end else begin
        send(1'b0, 0, $urandom_range(1000, 32'h7FFF_FFFF));
      end
    end
  endtask

  // Single-page grants freed every other one can leave more holes than the table holds.
  task automatic fragment(int n);
    range_t held[$];
    for (int j = 0; j < n; j++) begin
      while (pending_q.size() >= 3) @(posedge clk_i);
      send(1'b0, 0, 1);
    end
    drain();
    held = granted_q;
    granted_q.delete();
    for (int j = 0; j < held.size(); j += 2) begin
      while (pending_q.size() >= 3) @(posedge clk_i);
      send(1'b1, held[j].base, held[j].count);
    end
    for (int j = 1; j < held.size(); j += 2) granted_q.push_back(held[j]);
  endtask

  initial begin
    pool_base_q = 0;
    pool_pages_q = 0;
    reload_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Requests against the empty table left by reset.
    send(1'b0, 0, 1);
    send(1'b1, 36'hF_FFFF_FFFF, 0);
    send(1'b1, 7, 3);

    set_pool(1000, 100);
    send(1'b0, 0, 0);
    send(1'b1, 1000, 0);
    send(1'b0, 0, 10);
    send(1'b0, 0, 32'h7FFF_FFFF);
    send(1'b1, 1095, 2);
    send(1'b1, 1090, 5);
    send(1'b1, 1097, 1);
    send(1'b1, 1050, 1);
    send(1'b1, 1000, 1);
    send(1'b1, 990, 10);
    send(1'b0, 0, 108);
    send(1'b1, 5, 3);
    send(1'b0, 0, 3);
    send(1'b1, 36'hF_FFFF_FFFF, 32'h7FFF_FFFF);
    send(1'b0, 0, 32'h7FFF_FFFF);

    // Largest pool: merged lengths and the free total saturate.
    set_pool(0, 36'hF_FFFF_FFFF);
    send(1'b1, 36'hF_FFFF_FFFF, 5);
    send(1'b0, 0, 32'h7FFF_FFFF);
    send(1'b1, 36'hF_FFFF_FFFF - 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    set_pool(36'hF_FFFF_FFFF, 10);
    send(1'b0, 0, 4);
    send(1'b0, 0, 6);

    set_pool(36'hA_5A5A_5A5A, 0);
    random_traffic(30, 8);

    idle_on = 1'b1;
    set_pool(500, 300);
    fragment(160);
    random_traffic(300, 6);

    idle_on = 1'b0;
    set_pool({$urandom, $urandom}, 2000);
    random_traffic(300, 40);

    idle_on = 1'b1;
    set_pool(36'h5_A5A5_A5A5, 36'hF_0000_0000);
    random_traffic(200, 32'h7FFF_FFFF);

    set_pool(20, 250);
    fragment(120);
    random_traffic(400, 5);

    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
design/pea_pkg.sv
design/pea_table.sv
design/pea_alu.sv
design/page_extent_allocator_core.sv
tb/page_extent_allocator_core_tb.sv
